// ===== sv/assert_macros.svh =====
// Assertion macros shared by the moving average threshold crossing RTL.
// No dependencies; included by moving_average_threshold_crossing_unit, which carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define MAT_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define MAT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/mat_pkg.sv =====
// Package for the moving average threshold crossing unit: defaults, field widths,
// register indexes and the divider status struct. No dependencies.
package mat_pkg;

  // Defaults for the top-level parameters
  localparam int WINDOW_MAX_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed field widths
  localparam int WL_BITS        = 5;
  localparam int THR_BITS       = 16;
  localparam int CNT_BITS       = 32;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  // Register reset values
  localparam logic [WL_BITS-1:0]         WL_RESET  = 5'd5;
  localparam logic signed [THR_BITS-1:0] THR_RESET = 16'sd50;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD     = 2'd1;

  // Serial divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== sv/mat_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mat_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/mat_serial_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// Depends on mat_pkg (div_status_t).
module mat_serial_div #(
  parameter int DIVIDEND_BITS = 21,
  parameter int DIVISOR_BITS  = 5
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [DIVIDEND_BITS-1:0] dividend,
  input  logic [DIVISOR_BITS-1:0]  divisor,
  output logic [DIVIDEND_BITS-1:0] quotient,
  output mat_pkg::div_status_t     status
);

  localparam int STEP_BITS = (DIVIDEND_BITS > 1) ? $clog2(DIVIDEND_BITS) : 1;

  logic [DIVIDEND_BITS-1:0] quo;     // dividend shifts out, quotient shifts in
  logic [DIVISOR_BITS-1:0]  rem;
  logic [DIVISOR_BITS-1:0]  dvsr;
  logic [STEP_BITS-1:0]     step;
  logic                     busy;
  logic                     done;

  logic [DIVISOR_BITS:0]    trial;
  logic [DIVISOR_BITS:0]    trial_diff;
  logic                     fits;

  // one trial subtraction per cycle
  assign trial      = {rem, quo[DIVIDEND_BITS-1]};
  assign trial_diff = trial - {1'b0, dvsr};
  assign fits       = (trial >= {1'b0, dvsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= dividend;
        rem  <= '0;
        dvsr <= divisor;
        step <= STEP_BITS'(DIVIDEND_BITS - 1);
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= fits ? trial_diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
        quo  <= {quo[DIVIDEND_BITS-2:0], fits};
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient    = quo;
  assign status.busy = busy;
  assign status.done = done;

endmodule

// ===== sv/moving_average_threshold_crossing_unit.sv =====
// Moving average threshold crossing unit: averages the newest window_length samples,
// flags changes of the above-threshold state and counts them (saturating).
// Depends on mat_pkg, mat_ram, mat_serial_div and assert_macros.svh.
//
// One sample item is taken at a time. It passes the accept and read of the history
// RAM, then the update of the running sum, then the bit-serial divider (sum / fill
// count over a dividend of SAMPLE_BITS + clog2(WINDOW_MAX+1) bits, one quotient bit
// per cycle), and then waits to load the result register until the result is free.
// A new sample is accepted while a finished result still waits to be taken. Writing
// window_length empties the history at once; config writes are accepted only while
// no sample is in progress, and a pending config write takes priority over a waiting
// sample.
`include "assert_macros.svh"

module moving_average_threshold_crossing_unit #(
  parameter int WINDOW_MAX  = mat_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = mat_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // sample channel
  input  logic                                sample_valid,
  output logic                                sample_ready,
  input  logic signed [SAMPLE_BITS-1:0]       sample_value,
  // result channel
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic signed [SAMPLE_BITS-1:0]       smoothed_value,
  output logic                                is_above,
  output logic                                crossing_flag,
  output logic [mat_pkg::CNT_BITS-1:0]        crossings_total,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mat_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [mat_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int LEN_BITS  = $clog2(WINDOW_MAX + 1);
  localparam int PTR_BITS  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SUM_BITS  = SAMPLE_BITS + LEN_BITS;
  localparam int WLX_BITS  = (LEN_BITS > mat_pkg::WL_BITS) ? LEN_BITS : mat_pkg::WL_BITS;
  localparam int CMP_BITS  = (SAMPLE_BITS > mat_pkg::THR_BITS) ? SAMPLE_BITS
                                                               : mat_pkg::THR_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_HOLD
  } state_t;

  state_t                              state;
  logic [mat_pkg::WL_BITS-1:0]         window_length;
  logic signed [mat_pkg::THR_BITS-1:0] threshold;
  logic [PTR_BITS-1:0]                 write_pointer;
  logic [LEN_BITS-1:0]                 fill_count;
  logic signed [SUM_BITS-1:0]          running_sum;
  logic                                previous_above;
  logic [mat_pkg::CNT_BITS-1:0]        crossing_counter;

  // per-item payload
  logic signed [SAMPLE_BITS-1:0]       sample;
  logic [PTR_BITS-1:0]                 slot;
  logic                                sum_neg;

  // effective window length: zero acts as one, clamp at WINDOW_MAX
  logic [WLX_BITS-1:0] wl_ext;
  logic [WLX_BITS-1:0] len_w;
  logic [LEN_BITS-1:0] len;

  assign wl_ext = WLX_BITS'(window_length);
  assign len_w  = (window_length == '0) ? WLX_BITS'(1)
                : (wl_ext > WLX_BITS'(WINDOW_MAX)) ? WLX_BITS'(WINDOW_MAX) : wl_ext;
  assign len    = len_w[LEN_BITS-1:0];

  // ring slot for the incoming sample
  logic [PTR_BITS-1:0] slot_adj;
  assign slot_adj = (LEN_BITS'(write_pointer) >= len) ? '0 : write_pointer;

  // history RAM: read the oldest sample at accept, overwrite it in the following cycle
  logic [SAMPLE_BITS-1:0] old_sample;

  mat_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_history (
    .clk     (clk),
    .wr_en   (state == ST_READ),
    .wr_addr (slot),
    .wr_data (sample),
    .rd_addr (slot_adj),
    .rd_data (old_sample)
  );

  // running sum, fill count and pointer update
  logic                       window_full;
  logic signed [SUM_BITS-1:0] sum_next;
  logic [LEN_BITS-1:0]        fill_next;
  logic [LEN_BITS-1:0]        ptr_inc;
  logic [PTR_BITS-1:0]        pointer_next;
  logic [SUM_BITS-1:0]        sum_mag;

  assign window_full  = (fill_count >= len);
  assign sum_next     = running_sum
                      - (window_full ? SUM_BITS'(signed'(old_sample)) : SUM_BITS'(0))
                      + SUM_BITS'(sample);
  assign fill_next    = window_full ? len : (fill_count + 1'b1);
  assign ptr_inc      = LEN_BITS'(slot) + 1'b1;
  assign pointer_next = (ptr_inc >= len) ? '0 : ptr_inc[PTR_BITS-1:0];
  assign sum_mag      = sum_next[SUM_BITS-1] ? SUM_BITS'(-sum_next) : SUM_BITS'(sum_next);

  // serial divide of |sum| by the fill count
  logic [SUM_BITS-1:0]  quotient;
  mat_pkg::div_status_t div_status;

  mat_serial_div #(
    .DIVIDEND_BITS (SUM_BITS),
    .DIVISOR_BITS  (LEN_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_READ),
    .dividend (sum_mag),
    .divisor  (fill_next),
    .quotient (quotient),
    .status   (div_status)
  );

  // restore the sign, compare, detect the crossing
  logic [SUM_BITS-1:0]           avg_full;
  logic signed [SAMPLE_BITS-1:0] avg;
  logic signed [CMP_BITS-1:0]    avg_cmp;
  logic signed [CMP_BITS-1:0]    thr_cmp;
  logic                          above_now;
  logic                          crossing_now;
  logic                          load;

  assign avg_full     = sum_neg ? (~quotient + 1'b1) : quotient;
  assign avg          = signed'(avg_full[SAMPLE_BITS-1:0]);
  assign avg_cmp      = CMP_BITS'(avg);
  assign thr_cmp      = CMP_BITS'(threshold);
  assign above_now    = (avg_cmp > thr_cmp);
  assign crossing_now = (above_now != previous_above);
  assign load         = (state == ST_HOLD) && (!result_valid || result_ready);

  // config writes only between samples, ahead of a waiting sample
  assign cfg_ready    = (state == ST_IDLE);
  assign sample_ready = (state == ST_IDLE) && !cfg_valid;

  // state, registers and result outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      result_valid     <= 1'b0;
      window_length    <= mat_pkg::WL_RESET;
      threshold        <= mat_pkg::THR_RESET;
      write_pointer    <= '0;
      fill_count       <= '0;
      running_sum      <= '0;
      previous_above   <= 1'b0;
      crossing_counter <= '0;
    end else begin
      // result register: a new result replaces a taken one
      if (load) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (sample_valid && sample_ready) begin
            sample <= sample_value;
            slot   <= slot_adj;
            state  <= ST_READ;
          end
        end
        ST_READ: begin
          running_sum   <= sum_next;
          fill_count    <= fill_next;
          write_pointer <= pointer_next;
          sum_neg       <= sum_next[SUM_BITS-1];
          state         <= ST_DIV;
        end
        ST_DIV: begin
          if (div_status.done) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (load) begin
            smoothed_value <= avg;
            crossing_flag  <= crossing_now;
            previous_above <= above_now;
            if (crossing_now && (crossing_counter != '1)) begin
              crossing_counter <= crossing_counter + 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      // configuration writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mat_pkg::REG_WINDOW_LENGTH: begin
            window_length <= cfg_data[mat_pkg::WL_BITS-1:0];
            write_pointer <= '0;
            fill_count    <= '0;
            running_sum   <= '0;
          end
          mat_pkg::REG_THRESHOLD: begin
            threshold <= signed'(cfg_data[mat_pkg::THR_BITS-1:0]);
          end
          default: ;
        endcase
      end
    end
  end

  assign is_above        = previous_above;
  assign crossings_total = crossing_counter;

  // checks
  `MAT_ASSERT_IMPL(a_fill_in_window, clk, rst, 1'b1, fill_count <= len)
  `MAT_ASSERT_IMPL(a_ptr_in_window, clk, rst, state == ST_IDLE,
                   LEN_BITS'(write_pointer) < len)
  `MAT_ASSERT_IMPL(a_div_only_in_div, clk, rst, div_status.busy || div_status.done,
                   state == ST_DIV)

endmodule
